[hw/rtl/cor_pkg.sv]
package cor_pkg;

	// extra fraction bits carried by the centre distance
	localparam int DIST_EXTRA = 8;
	// radius integer bits
	localparam int RAD_INT_BITS = 4;
	// axis reach beyond which no overlap is possible, as a power of two over the fraction
	localparam int REACH_EXTRA = 5;

endpackage

[hw/rtl/cor_isqrt.sv]
module cor_isqrt #(
	parameter int RW = 44,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [RW-1:0]   radicand,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [RW/2-1:0] root,
	output logic [SW-1:0]   out_side
);

	localparam int N = RW / 2;

	logic [N+1:0]  rem_s  [N];
	logic [N-1:0]  root_s [N];
	logic [RW-1:0] rad_s  [N];
	logic [SW-1:0] side_s [N];
	logic          vld_s  [N];

	// one result bit per stage
	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [N+1:0]  rem_c;
		logic [N-1:0]  root_c;
		logic [RW-1:0] rad_c;
		logic [SW-1:0] side_c;
		logic          vld_c;
		logic [N+1:0]  nrem;
		logic [N+1:0]  trial;

		if (i == 0) begin : g_first
			assign rem_c  = '0;
			assign root_c = '0;
			assign rad_c  = radicand;
			assign side_c = in_side;
			assign vld_c  = in_valid;
		end else begin : g_next
			assign rem_c  = rem_s[i-1];
			assign root_c = root_s[i-1];
			assign rad_c  = rad_s[i-1];
			assign side_c = side_s[i-1];
			assign vld_c  = vld_s[i-1];
		end

		assign nrem  = {rem_c[N-1:0], rad_c[RW-1 -: 2]};
		assign trial = {root_c, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (nrem >= trial) begin
					rem_s[i]  <= nrem - trial;
					root_s[i] <= {root_c[N-2:0], 1'b1};
				end else begin
					rem_s[i]  <= nrem;
					root_s[i] <= {root_c[N-2:0], 1'b0};
				end
				rad_s[i]  <= rad_c << 2;
				side_s[i] <= side_c;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign root      = root_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

[hw/rtl/cor_div.sv]
module cor_div #(
	parameter int NW = 35,
	parameter int DW = 23,
	parameter int Q  = 13,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num_a,
	input  logic [NW-1:0] num_b,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [Q-1:0]  quo_a,
	output logic [Q-1:0]  quo_b,
	output logic [SW-1:0] out_side
);

	logic [NW-1:0] na_s  [Q];
	logic [NW-1:0] nb_s  [Q];
	logic [Q-1:0]  qa_s  [Q];
	logic [Q-1:0]  qb_s  [Q];
	logic [DW-1:0] den_s [Q];
	logic [SW-1:0] side_s[Q];
	logic          vld_s [Q];

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < Q; k++) begin : g_stage
		logic [NW-1:0] na_c;
		logic [NW-1:0] nb_c;
		logic [Q-1:0]  qa_c;
		logic [Q-1:0]  qb_c;
		logic [DW-1:0] den_c;
		logic [SW-1:0] side_c;
		logic          vld_c;
		logic [NW-1:0] dsh;
		logic          a_ge;
		logic          b_ge;

		if (k == 0) begin : g_first
			assign na_c   = num_a;
			assign nb_c   = num_b;
			assign qa_c   = '0;
			assign qb_c   = '0;
			assign den_c  = den;
			assign side_c = in_side;
			assign vld_c  = in_valid;
		end else begin : g_next
			assign na_c   = na_s[k-1];
			assign nb_c   = nb_s[k-1];
			assign qa_c   = qa_s[k-1];
			assign qb_c   = qb_s[k-1];
			assign den_c  = den_s[k-1];
			assign side_c = side_s[k-1];
			assign vld_c  = vld_s[k-1];
		end

		assign dsh  = NW'(den_c) << (Q - 1 - k);
		assign a_ge = na_c >= dsh;
		assign b_ge = nb_c >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				na_s[k]   <= a_ge ? na_c - dsh : na_c;
				nb_s[k]   <= b_ge ? nb_c - dsh : nb_c;
				qa_s[k]   <= {qa_c[Q-2:0], a_ge};
				qb_s[k]   <= {qb_c[Q-2:0], b_ge};
				den_s[k]  <= den_c;
				side_s[k] <= side_c;
			end
		end
	end

	assign out_valid = vld_s[Q-1];
	assign quo_a     = qa_s[Q-1];
	assign quo_b     = qb_s[Q-1];
	assign out_side  = side_s[Q-1];

endmodule

[hw/rtl/circle_overlap_resolver.sv]
// Circle overlap resolver: accepts one candidate pair per cycle while not
// stalled and returns the corrected centres and an overlap flag (default
// Q12.8 format). The pipeline is three input stages, one stage per root bit
// of the distance square root (POS_FRAC_BITS + 14), three stages for overlap,
// product and rounding term, one stage per quotient bit of the shared axis
// divider (POS_FRAC_BITS + 5) and the output register. When a result is held
// by stall the whole pipeline halts and in_stall is raised in the same cycle;
// otherwise a transaction enters every cycle.
module circle_overlap_resolver #(
	parameter int POS_FRAC_BITS = 8,
	parameter int POS_INT_BITS  = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [POS_INT_BITS+POS_FRAC_BITS-1:0] first_x,
	input  logic [POS_INT_BITS+POS_FRAC_BITS-1:0] first_y,
	input  logic [POS_INT_BITS+POS_FRAC_BITS-1:0] second_x,
	input  logic [POS_INT_BITS+POS_FRAC_BITS-1:0] second_y,
	input  logic [POS_FRAC_BITS+3:0]              first_radius,
	input  logic [POS_FRAC_BITS+3:0]              second_radius,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [POS_INT_BITS+POS_FRAC_BITS-1:0] new_first_x,
	output logic [POS_INT_BITS+POS_FRAC_BITS-1:0] new_first_y,
	output logic [POS_INT_BITS+POS_FRAC_BITS-1:0] new_second_x,
	output logic [POS_INT_BITS+POS_FRAC_BITS-1:0] new_second_y,
	output logic                                  overlapped
);

	localparam int F    = POS_FRAC_BITS;
	localparam int PW   = POS_INT_BITS + POS_FRAC_BITS;
	localparam int RADW = F + cor_pkg::RAD_INT_BITS;
	localparam int AW   = F + cor_pkg::REACH_EXTRA;
	localparam int SQW  = 2 * AW;
	localparam int D2W  = SQW + 1;
	localparam int RW   = 2 * ((D2W + 2 * cor_pkg::DIST_EXTRA + 1) / 2);
	localparam int N    = RW / 2;
	localparam int DLW  = AW + cor_pkg::DIST_EXTRA;
	localparam int PRW  = DLW + AW;
	localparam int NW   = PRW + 1;
	localparam int DW   = N + 1;
	localparam int Q    = AW;
	localparam int SSW  = 4 * PW + 2 + 2 * AW + AW + 1;
	localparam int DSW  = 4 * PW + 3;

	logic en;
	assign en       = !out_stall || !out_valid;
	assign in_stall = !en;

	// stage 1: differences, reach and radius sum
	logic [PW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic          nx_s1, ny_s1, near_s1, v_s1;
	logic [AW-1:0] adx_s1, ady_s1, sum_s1;
	logic [PW-1:0] adx_full, ady_full;

	assign adx_full = (first_x < second_x) ? second_x - first_x : first_x - second_x;
	assign ady_full = (first_y < second_y) ? second_y - first_y : first_y - second_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= first_x;
			ay_s1   <= first_y;
			bx_s1   <= second_x;
			by_s1   <= second_y;
			nx_s1   <= first_x < second_x;
			ny_s1   <= first_y < second_y;
			adx_s1  <= adx_full[AW-1:0];
			ady_s1  <= ady_full[AW-1:0];
			near_s1 <= (adx_full[PW-1:AW] == '0) && (ady_full[PW-1:AW] == '0);
			sum_s1  <= AW'(first_radius) + AW'(second_radius);
		end
	end

	// stage 2: squares
	logic [PW-1:0]  ax_s2, ay_s2, bx_s2, by_s2;
	logic           nx_s2, ny_s2, near_s2, v_s2;
	logic [AW-1:0]  adx_s2, ady_s2, sum_s2;
	logic [SQW-1:0] sqx_s2, sqy_s2, sqs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
			nx_s2   <= nx_s1;
			ny_s2   <= ny_s1;
			near_s2 <= near_s1;
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			sum_s2  <= sum_s1;
			sqx_s2  <= adx_s1 * adx_s1;
			sqy_s2  <= ady_s1 * ady_s1;
			sqs_s2  <= sum_s1 * sum_s1;
		end
	end

	// stage 3: overlap test and radicand
	logic [PW-1:0]  ax_s3, ay_s3, bx_s3, by_s3;
	logic           nx_s3, ny_s3, hit_s3, v_s3;
	logic [AW-1:0]  adx_s3, ady_s3, sum_s3;
	logic [RW-1:0]  rad_s3;
	logic [D2W-1:0] d2;
	logic           hit_c;

	assign d2    = D2W'(sqx_s2) + D2W'(sqy_s2);
	assign hit_c = near_s2 && (d2 != '0) && (d2 < D2W'(sqs_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			bx_s3  <= bx_s2;
			by_s3  <= by_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			adx_s3 <= adx_s2;
			ady_s3 <= ady_s2;
			sum_s3 <= sum_s2;
			hit_s3 <= hit_c;
			rad_s3 <= hit_c ? RW'(d2) << (2 * cor_pkg::DIST_EXTRA) : '0;
		end
	end

	// distance square root
	logic [SSW-1:0] sq_side_in, sq_side_out;
	logic [N-1:0]   root_dist;
	logic           v_sq;
	logic [PW-1:0]  ax_r, ay_r, bx_r, by_r;
	logic           nx_r, ny_r, hit_r;
	logic [AW-1:0]  adx_r, ady_r, sum_r;

	assign sq_side_in = {ax_s3, ay_s3, bx_s3, by_s3, nx_s3, ny_s3,
		adx_s3, ady_s3, sum_s3, hit_s3};
	assign {ax_r, ay_r, bx_r, by_r, nx_r, ny_r, adx_r, ady_r, sum_r, hit_r} = sq_side_out;

	cor_isqrt #(
		.RW (RW),
		.SW (SSW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  (rad_s3),
		.in_side   (sq_side_in),
		.out_valid (v_sq),
		.root      (root_dist),
		.out_side  (sq_side_out)
	);

	// stage 4: overlap depth
	logic [PW-1:0]  ax_s4, ay_s4, bx_s4, by_s4;
	logic           nx_s4, ny_s4, hit_s4, v_s4;
	logic [AW-1:0]  adx_s4, ady_s4;
	logic [DLW-1:0] delta_s4;
	logic [N-1:0]   dist_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s4    <= ax_r;
			ay_s4    <= ay_r;
			bx_s4    <= bx_r;
			by_s4    <= by_r;
			nx_s4    <= nx_r;
			ny_s4    <= ny_r;
			hit_s4   <= hit_r;
			adx_s4   <= adx_r;
			ady_s4   <= ady_r;
			dist_s4  <= root_dist;
			delta_s4 <= {sum_r, {cor_pkg::DIST_EXTRA{1'b0}}} - DLW'(root_dist);
		end
	end

	// stage 5: products
	logic [PW-1:0]  ax_s5, ay_s5, bx_s5, by_s5;
	logic           nx_s5, ny_s5, hit_s5, v_s5;
	logic [PRW-1:0] px_s5, py_s5;
	logic [N-1:0]   dist_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
			bx_s5   <= bx_s4;
			by_s5   <= by_s4;
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
			hit_s5  <= hit_s4;
			dist_s5 <= dist_s4;
			px_s5   <= delta_s4 * adx_s4;
			py_s5   <= delta_s4 * ady_s4;
		end
	end

	// stage 6: rounding term and divisor
	logic [PW-1:0] ax_s6, ay_s6, bx_s6, by_s6;
	logic          nx_s6, ny_s6, hit_s6, v_s6;
	logic [NW-1:0] numx_s6, numy_s6;
	logic [DW-1:0] den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s6   <= ax_s5;
			ay_s6   <= ay_s5;
			bx_s6   <= bx_s5;
			by_s6   <= by_s5;
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			hit_s6  <= hit_s5;
			numx_s6 <= NW'(px_s5) + NW'(dist_s5);
			numy_s6 <= NW'(py_s5) + NW'(dist_s5);
			den_s6  <= {dist_s5, 1'b0};
		end
	end

	// axis shifts
	logic [DSW-1:0] dv_side_in, dv_side_out;
	logic [Q-1:0]   mx, my;
	logic           v_dv;
	logic [PW-1:0]  ax_d, ay_d, bx_d, by_d;
	logic           nx_d, ny_d, hit_d;

	assign dv_side_in = {ax_s6, ay_s6, bx_s6, by_s6, nx_s6, ny_s6, hit_s6};
	assign {ax_d, ay_d, bx_d, by_d, nx_d, ny_d, hit_d} = dv_side_out;

	cor_div #(
		.NW (NW),
		.DW (DW),
		.Q  (Q),
		.SW (DSW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num_a     (numx_s6),
		.num_b     (numy_s6),
		.den       (den_s6),
		.in_side   (dv_side_in),
		.out_valid (v_dv),
		.quo_a     (mx),
		.quo_b     (my),
		.out_side  (dv_side_out)
	);

	function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] p, input logic [Q-1:0] m);
		logic [PW:0] s;
		s = {1'b0, p} + (PW+1)'(m);
		return s[PW] ? '1 : s[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] sat_sub(input logic [PW-1:0] p, input logic [Q-1:0] m);
		logic [PW:0] s;
		s = {1'b0, p} - (PW+1)'(m);
		return s[PW] ? '0 : s[PW-1:0];
	endfunction

	// output register
	logic [Q-1:0] sx, sy;
	assign sx = hit_d ? mx : '0;
	assign sy = hit_d ? my : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_first_x  <= nx_d ? sat_sub(ax_d, sx) : sat_add(ax_d, sx);
			new_second_x <= nx_d ? sat_add(bx_d, sx) : sat_sub(bx_d, sx);
			new_first_y  <= ny_d ? sat_sub(ay_d, sy) : sat_add(ay_d, sy);
			new_second_y <= ny_d ? sat_add(by_d, sy) : sat_sub(by_d, sy);
			overlapped   <= hit_d;
		end
	end

endmodule
